// File: hw/rtl/cfev_pkg.sv
// ----------------------------------------------------------------------------
// cfev_pkg
// Shared types and constants for the checked frame envelope verifier: header
// layout, magic word, FNV-1a 64 offset basis, status codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package cfev_pkg;

    localparam int unsigned HEADER_BYTES = 28;
    localparam int unsigned COUNT_W      = 33;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Header field offsets
    localparam int unsigned OFS_VERSION  = 8;
    localparam int unsigned OFS_RESERVED = 10;
    localparam int unsigned OFS_LENGTH   = 12;
    localparam int unsigned OFS_CHECKSUM = 20;

    // "SWPCKPT1", first byte in the low lane
    localparam logic [63:0] MAGIC_WORD = 64'h3154_504B_4350_5753;

    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

    // Status codes
    localparam logic [3:0] STATUS_OK        = 4'd0;
    localparam logic [3:0] STATUS_LIMIT     = 4'd1;
    localparam logic [3:0] STATUS_TRUNCATED = 4'd2;
    localparam logic [3:0] STATUS_MAGIC     = 4'd3;
    localparam logic [3:0] STATUS_VERSION   = 4'd4;
    localparam logic [3:0] STATUS_INVALID   = 4'd5;
    localparam logic [3:0] STATUS_TRAILING  = 4'd6;
    localparam logic [3:0] STATUS_CHECKSUM  = 4'd7;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES        = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_VERSION = 1'd1;

    localparam logic [31:0] MAX_BYTES_RESET        = 32'hFFFF_FFFF;
    localparam logic [15:0] PROTOCOL_VERSION_RESET = 16'd1;

    // Frame state captured on the final byte, handed to the status check
    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic               magic_ok;
        logic [15:0]        version;
        logic [15:0]        reserved;
        logic [63:0]        length;
        logic [63:0]        checksum;
        logic [63:0]        hash;
    } frame_snap_t;

endpackage

`default_nettype wire

// File: hw/rtl/checked_frame_envelope_verifier_core.sv
// ----------------------------------------------------------------------------
// checked_frame_envelope_verifier_core
// Checks a framed buffer with a 28-byte envelope and an FNV-1a 64 checksum
// over the payload, one byte per cycle while the input is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one buffer byte per item (data_byte) with last
//   set on the final byte. For every item with last set, one result item is
//   given on the output channel: status, the header's payload_length and the
//   computed_checksum. Items without last give no result.
//   Throughput is one byte per cycle while in_stall is low, set by the hash
//   loop: one xor and a shift-and-add multiply by the FNV prime per cycle on
//   the running hash. The result is registered in the capture stage on the
//   final byte, then in the output register after the status is evaluated.
//   The input stalls only when both the capture stage and the output
//   register are full and the receiver holds out_stall; a held result stays
//   unchanged until taken.
//   Configuration (cfg_index 0: max_bytes, 1: protocol_version) is written
//   through cfg_valid/cfg_ready; the user must write it only while no frame
//   is in flight, as the block does not enforce this. cfg_ready is always high.
//   Reset clears the frame state, sets max_bytes to all ones and
//   protocol_version to 1, and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module checked_frame_envelope_verifier_core
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [7:0]                     data_byte,
    input  wire logic                           last,

    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [3:0]                     status,
    output logic      [63:0]                    payload_length,
    output logic      [63:0]                    computed_checksum,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [cfev_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_data
);

    localparam int unsigned CW = cfev_pkg::COUNT_W;

    // Configuration
    logic [31:0] max_bytes_reg;
    logic [15:0] protocol_version_reg;

    // Frame state
    logic [CW-1:0] count_reg;
    logic          magic_ok_reg;
    logic [15:0]   version_reg;
    logic [15:0]   reserved_reg;
    logic [63:0]   length_reg;
    logic [63:0]   checksum_reg;
    logic [63:0]   hash_reg;

    logic [CW-1:0] count_next;
    logic          magic_ok_next;
    logic [15:0]   version_next;
    logic [15:0]   reserved_next;
    logic [63:0]   length_next;
    logic [63:0]   checksum_next;
    logic [63:0]   hash_next;
    logic [63:0]   hash_step;

    // Capture stage and output register
    logic                  snap_valid_reg;
    cfev_pkg::frame_snap_t snap_reg;
    logic                  out_valid_reg;
    logic [3:0]            status_reg;
    logic [63:0]           length_out_reg;
    logic [63:0]           hash_out_reg;
    logic [3:0]            status_calc;

    logic in_accept;
    logic out_take;
    logic snap_load;
    logic in_header;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg        <= cfev_pkg::MAX_BYTES_RESET;
            protocol_version_reg <= cfev_pkg::PROTOCOL_VERSION_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cfev_pkg::REG_MAX_BYTES:        max_bytes_reg        <= cfg_data;
                cfev_pkg::REG_PROTOCOL_VERSION: protocol_version_reg <= cfg_data[15:0];
                default:                        ;
            endcase
        end
    end

    // Handshake
    assign out_take  = !out_valid_reg || !out_stall;
    assign in_stall  = snap_valid_reg && !out_take;
    assign in_accept = in_valid && !in_stall;
    assign snap_load = in_accept && last;

    cfev_hash_step u_hash_step
    (
        .hash      (hash_reg),
        .data_byte (data_byte),
        .hash_next (hash_step)
    );

    // Fold the incoming byte into the frame state
    always_comb
    begin
        in_header     = count_reg < CW'(cfev_pkg::HEADER_BYTES);
        count_next    = (count_reg == cfev_pkg::COUNT_MAX) ? count_reg : count_reg + CW'(1);
        magic_ok_next = magic_ok_reg;
        version_next  = version_reg;
        reserved_next = reserved_reg;
        length_next   = length_reg;
        checksum_next = checksum_reg;
        hash_next     = in_header ? hash_reg : hash_step;

        for (int i = 0; i < 8; i++)
        begin
            if (count_reg == CW'(i) && data_byte != cfev_pkg::MAGIC_WORD[8*i +: 8])
                magic_ok_next = 1'b0;
            if (count_reg == CW'(cfev_pkg::OFS_LENGTH + i))
                length_next[8*i +: 8] = data_byte;
            if (count_reg == CW'(cfev_pkg::OFS_CHECKSUM + i))
                checksum_next[8*i +: 8] = data_byte;
        end
        for (int i = 0; i < 2; i++)
        begin
            if (count_reg == CW'(cfev_pkg::OFS_VERSION + i))
                version_next[8*i +: 8] = data_byte;
            if (count_reg == CW'(cfev_pkg::OFS_RESERVED + i))
                reserved_next[8*i +: 8] = data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            magic_ok_reg <= 1'b1;
            version_reg  <= '0;
            reserved_reg <= '0;
            length_reg   <= '0;
            checksum_reg <= '0;
            hash_reg     <= cfev_pkg::FNV_BASIS;
        end
        else if (in_accept)
        begin
            if (last)
            begin
                // start a fresh frame on the next item
                count_reg    <= '0;
                magic_ok_reg <= 1'b1;
                version_reg  <= '0;
                reserved_reg <= '0;
                length_reg   <= '0;
                checksum_reg <= '0;
                hash_reg     <= cfev_pkg::FNV_BASIS;
            end
            else
            begin
                count_reg    <= count_next;
                magic_ok_reg <= magic_ok_next;
                version_reg  <= version_next;
                reserved_reg <= reserved_next;
                length_reg   <= length_next;
                checksum_reg <= checksum_next;
                hash_reg     <= hash_next;
            end
        end
    end

    // Capture stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (snap_load)
            snap_valid_reg <= 1'b1;
        else if (out_take)
            snap_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            snap_reg.byte_count <= count_next;
            snap_reg.magic_ok   <= magic_ok_next;
            snap_reg.version    <= version_next;
            snap_reg.reserved   <= reserved_next;
            snap_reg.length     <= length_next;
            snap_reg.checksum   <= checksum_next;
            snap_reg.hash       <= hash_next;
        end
    end

    cfev_status_eval u_status_eval
    (
        .snap             (snap_reg),
        .max_bytes        (max_bytes_reg),
        .protocol_version (protocol_version_reg),
        .status           (status_calc)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (snap_valid_reg && out_take)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (snap_valid_reg && out_take)
        begin
            status_reg     <= status_calc;
            length_out_reg <= snap_reg.length;
            hash_out_reg   <= snap_reg.hash;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign payload_length    = length_out_reg;
    assign computed_checksum = hash_out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/cfev_hash_step.sv
// ----------------------------------------------------------------------------
// cfev_hash_step
// One FNV-1a 64 round: xor in a byte, then multiply by the FNV prime
// 2^40 + 2^8 + 0xB3, built as a sum of shifted copies.
// ----------------------------------------------------------------------------
`default_nettype none

module cfev_hash_step
(
    input  wire logic [63:0] hash,
    input  wire logic [7:0]  data_byte,
    output logic      [63:0] hash_next
);

    logic [63:0] mixed;

    always_comb
    begin
        mixed = hash ^ {56'd0, data_byte};
        // prime = 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 2^0
        hash_next = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
                  + (mixed << 4) + (mixed << 1) + mixed;
    end

endmodule

`default_nettype wire

// File: hw/rtl/cfev_status_eval.sv
// ----------------------------------------------------------------------------
// cfev_status_eval
// Status decision for one finished frame, checked in priority order from the
// byte limit down to the checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module cfev_status_eval
(
    input  wire cfev_pkg::frame_snap_t snap,
    input  wire logic [31:0]           max_bytes,
    input  wire logic [15:0]           protocol_version,
    output logic      [3:0]            status
);

    logic [cfev_pkg::COUNT_W-1:0] avail;
    logic                         len_high;
    logic                         len_gt;
    logic                         len_lt;
    logic                         over_limit;
    logic                         short_hdr;

    always_comb
    begin
        over_limit = (max_bytes < 32'(cfev_pkg::HEADER_BYTES))
                  || (snap.byte_count > {1'b0, max_bytes});
        short_hdr  = snap.byte_count < cfev_pkg::COUNT_W'(cfev_pkg::HEADER_BYTES);
        avail      = snap.byte_count - cfev_pkg::COUNT_W'(cfev_pkg::HEADER_BYTES);
        // upper length bits set means more than any byte count can hold
        len_high   = |snap.length[63:cfev_pkg::COUNT_W];
        len_gt     = len_high || (snap.length[cfev_pkg::COUNT_W-1:0] > avail);
        len_lt     = !len_high && (snap.length[cfev_pkg::COUNT_W-1:0] < avail);

        if (over_limit)
            status = cfev_pkg::STATUS_LIMIT;
        else if (short_hdr)
            status = cfev_pkg::STATUS_TRUNCATED;
        else if (!snap.magic_ok)
            status = cfev_pkg::STATUS_MAGIC;
        else if (snap.version != protocol_version)
            status = cfev_pkg::STATUS_VERSION;
        else if (snap.reserved != 16'd0)
            status = cfev_pkg::STATUS_INVALID;
        else if (len_gt)
            status = cfev_pkg::STATUS_TRUNCATED;
        else if (len_lt)
            status = cfev_pkg::STATUS_TRAILING;
        else if (snap.hash != snap.checksum)
            status = cfev_pkg::STATUS_CHECKSUM;
        else
            status = cfev_pkg::STATUS_OK;
    end

endmodule

`default_nettype wire

// File: test/frame_check_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_check_scoreboard_pkg
// Scoreboard for the frame envelope verifier. It tracks the register settings
// and the header fields and payload hash of the frame that is being received.
// On each final byte it forms the verdict it expects, then matches the block's
// results against those verdicts in order.
// ----------------------------------------------------------------------------
package frame_check_scoreboard_pkg;

    import cfev_pkg::*;

    localparam logic [63:0] FNV_PRIME    = 64'h0000_0100_0000_01B3;
    // 'S' in the top byte, so byte k of the envelope is bits [8*(7-k) +: 8]
    localparam logic [63:0] ENVELOPE_TAG = "SWPCKPT1";

    typedef struct packed {
        logic [3:0]  status;
        logic [63:0] length;
        logic [63:0] checksum;
    } frame_verdict_t;

    class frame_check_scoreboard;
        logic [31:0]        max_bytes;
        logic [15:0]        wanted_version;
        logic [COUNT_W-1:0] seen_bytes;
        logic               magic_match;
        logic [15:0]        hdr_version;
        logic [15:0]        hdr_reserved;
        logic [63:0]        hdr_length;
        logic [63:0]        hdr_checksum;
        logic [63:0]        payload_hash;
        frame_verdict_t     verdicts[$];
        int unsigned        mismatches;
        int unsigned        frames_checked;
        int unsigned        status_tally[8];

        function new();
            max_bytes      = MAX_BYTES_RESET;
            wanted_version = PROTOCOL_VERSION_RESET;
            mismatches     = 0;
            frames_checked = 0;
            foreach (status_tally[i])
                status_tally[i] = 0;
            clear_frame();
        endfunction

        static function logic [63:0] fold_byte(logic [63:0] h, logic [7:0] b);
            return (h ^ {56'd0, b}) * FNV_PRIME;
        endfunction

        function void clear_frame();
            seen_bytes   = '0;
            magic_match  = 1'b1;
            hdr_version  = '0;
            hdr_reserved = '0;
            hdr_length   = '0;
            hdr_checksum = '0;
            payload_hash = FNV_BASIS;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            if (idx == REG_MAX_BYTES)
                max_bytes = value;
            else if (idx == REG_PROTOCOL_VERSION)
                wanted_version = value[15:0];
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        function logic [3:0] frame_status();
            logic [COUNT_W-1:0] spare;
            if (max_bytes < HEADER_BYTES || seen_bytes > {1'b0, max_bytes})
                return STATUS_LIMIT;
            if (seen_bytes < HEADER_BYTES)
                return STATUS_TRUNCATED;
            if (!magic_match)
                return STATUS_MAGIC;
            if (hdr_version != wanted_version)
                return STATUS_VERSION;
            if (hdr_reserved != 16'd0)
                return STATUS_INVALID;
            spare = seen_bytes - HEADER_BYTES;
            if (hdr_length > {31'd0, spare})
                return STATUS_TRUNCATED;
            if (hdr_length < {31'd0, spare})
                return STATUS_TRAILING;
            if (payload_hash != hdr_checksum)
                return STATUS_CHECKSUM;
            return STATUS_OK;
        endfunction

        // Fold one accepted item into the frame; queue a verdict on the last one
        function void note_byte(logic [7:0] b, logic is_last);
            frame_verdict_t v;
            int unsigned    pos;
            pos = seen_bytes[31:0];
            if (seen_bytes < OFS_VERSION)
            begin
                if (b != ENVELOPE_TAG[8*(7-pos) +: 8])
                    magic_match = 1'b0;
            end
            else if (seen_bytes < OFS_RESERVED)
                hdr_version[8*(pos-OFS_VERSION) +: 8] = b;
            else if (seen_bytes < OFS_LENGTH)
                hdr_reserved[8*(pos-OFS_RESERVED) +: 8] = b;
            else if (seen_bytes < OFS_CHECKSUM)
                hdr_length[8*(pos-OFS_LENGTH) +: 8] = b;
            else if (seen_bytes < HEADER_BYTES)
                hdr_checksum[8*(pos-OFS_CHECKSUM) +: 8] = b;
            else
                payload_hash = fold_byte(payload_hash, b);
            if (seen_bytes != COUNT_MAX)
                seen_bytes = seen_bytes + 1'b1;
            if (is_last)
            begin
                v.status   = frame_status();
                v.length   = hdr_length;
                v.checksum = payload_hash;
                verdicts.push_back(v);
                clear_frame();
            end
        endfunction

        function void check_result(logic [3:0] st, logic [63:0] len, logic [63:0] sum);
            frame_verdict_t v;
            if (verdicts.size() == 0)
            begin
                $error("result with no frame pending: status %0d length %h checksum %h",
                       st, len, sum);
                mismatches++;
                return;
            end
            v = verdicts.pop_front();
            frames_checked++;
            if (v.status < 8)
                status_tally[v.status]++;
            if (st !== v.status)
            begin
                $error("status: expected %0d, got %0d", v.status, st);
                mismatches++;
            end
            if (len !== v.length)
            begin
                $error("payload_length: expected %h, got %h", v.length, len);
                mismatches++;
            end
            if (sum !== v.checksum)
            begin
                $error("computed_checksum: expected %h, got %h", v.checksum, sum);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// File: test/checked_frame_envelope_verifier_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// checked_frame_envelope_verifier_core_test
// Streams framed buffers through the envelope verifier: a directed set of
// clean, damaged and short frames under extreme register settings, then
// random frames under several settings with idling on both sides, one no-idle
// stretch and one long hold on the result side. Every result is checked
// field by field against the scoreboard's verdict.
// ----------------------------------------------------------------------------
module checked_frame_envelope_verifier_core_test;

    import cfev_pkg::*;
    import frame_check_scoreboard_pkg::*;

    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned STALL_LIMIT = 2000;

    typedef enum {
        FLAW_CLEAN,
        FLAW_MAGIC,
        FLAW_VERSION,
        FLAW_RESERVED,
        FLAW_LONG_DECL,
        FLAW_SHORT_DECL,
        FLAW_BAD_SUM,
        FLAW_CUT,
        FLAW_NOISE
    } frame_flaw_e;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [7:0]           data_byte;
    logic                 last;
    logic                 out_valid;
    logic                 out_stall;
    logic [3:0]           status;
    logic [63:0]          payload_length;
    logic [63:0]          computed_checksum;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    frame_check_scoreboard sb;
    logic [7:0]            frame_bytes[$];
    logic [15:0]           cur_version;
    bit                    steady_run   = 1'b0;
    bit                    pressure_req = 1'b0;
    int unsigned           bytes_taken  = 0;
    int unsigned           settings_run = 0;
    int unsigned           quiet_cycles = 0;

    checked_frame_envelope_verifier_core uut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .data_byte         (data_byte),
        .last              (last),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .payload_length    (payload_length),
        .computed_checksum (computed_checksum),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitors: everything seen at an edge is the value from before that edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
            begin
                sb.note_byte(data_byte, last);
                bytes_taken++;
            end
            if (out_valid && !out_stall)
                sb.check_result(status, payload_length, computed_checksum);
        end
    end

    // Watchdog: count edges at which no channel moves an item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout after %0d cycles with no item moving", quiet_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Result side: random stalls, or one long hold when asked
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_req)
            begin
                pressure_req = 1'b0;
                out_stall <= 1'b1;
                for (int unsigned n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
            end
            else
                out_stall <= !steady_run && ($urandom_range(99) < 27);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic is_last);
        while (!steady_run && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last      <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // Build a frame for the current version; fill < 0 gives a random payload
    task automatic build_frame(input frame_flaw_e flaw, input int unsigned pay_n,
                               input int fill);
        logic [63:0] sum;
        logic [63:0] len;
        logic [15:0] ver;
        logic [15:0] rsv;
        logic [7:0]  b;
        logic [7:0]  payload[$];
        int unsigned keep;
        int unsigned k;
        frame_bytes.delete();
        if (flaw == FLAW_NOISE)
        begin
            repeat ($urandom_range(80, 1))
                frame_bytes.push_back(8'($urandom_range(255)));
            return;
        end
        keep = 0;
        if (flaw == FLAW_CUT)
        begin
            keep  = pay_n;
            pay_n = 0;
        end
        if (flaw == FLAW_SHORT_DECL && pay_n == 0)
            pay_n = 1;
        sum = FNV_BASIS;
        for (k = 0; k < pay_n; k++)
        begin
            b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
            payload.push_back(b);
            sum = frame_check_scoreboard::fold_byte(sum, b);
        end
        ver = cur_version;
        rsv = 16'd0;
        len = 64'(pay_n);
        case (flaw)
            FLAW_VERSION:    ver = cur_version ^ 16'($urandom_range(65535, 1));
            FLAW_RESERVED:   rsv = 16'($urandom_range(65535, 1));
            FLAW_LONG_DECL:
                if ($urandom_range(1) == 1)
                    len = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
                else
                    len = len + $urandom_range(6, 1);
            FLAW_SHORT_DECL: len = len - $urandom_range(pay_n, 1);
            FLAW_BAD_SUM:    sum = sum ^ {$urandom, $urandom | 32'd1};
            default: ;
        endcase
        for (k = 0; k < 8; k++)
            frame_bytes.push_back(ENVELOPE_TAG[8*(7-k) +: 8]);
        if (flaw == FLAW_MAGIC)
        begin
            k = $urandom_range(7);
            frame_bytes[k] = frame_bytes[k] ^ (8'd1 << $urandom_range(7));
        end
        frame_bytes.push_back(ver[7:0]);
        frame_bytes.push_back(ver[15:8]);
        frame_bytes.push_back(rsv[7:0]);
        frame_bytes.push_back(rsv[15:8]);
        for (k = 0; k < 8; k++)
            frame_bytes.push_back(len[8*k +: 8]);
        for (k = 0; k < 8; k++)
            frame_bytes.push_back(sum[8*k +: 8]);
        foreach (payload[i])
            frame_bytes.push_back(payload[i]);
        if (flaw == FLAW_CUT)
            while (frame_bytes.size() > keep)
                void'(frame_bytes.pop_back());
    endtask

    task automatic send_case(input frame_flaw_e flaw, input int unsigned pay_n,
                             input int fill);
        build_frame(flaw, pay_n, fill);
        send_frame();
    endtask

    // Drop valid, let the monitor see the last item, drain every pending verdict
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic set_registers(input logic [31:0] max_len, input logic [15:0] ver);
        settle();
        write_register(REG_MAX_BYTES, max_len);
        write_register(REG_PROTOCOL_VERSION, 32'(ver));
        cfg_valid   <= 1'b0;
        cur_version = ver;
        settings_run++;
    endtask

    task automatic run_random(input int unsigned budget);
        int unsigned sent;
        int unsigned r;
        int unsigned pay_n;
        frame_flaw_e flaw;
        sent = 0;
        while (sent < budget)
        begin
            r = $urandom_range(99);
            if (r < 55)      flaw = FLAW_CLEAN;
            else if (r < 61) flaw = FLAW_MAGIC;
            else if (r < 67) flaw = FLAW_VERSION;
            else if (r < 73) flaw = FLAW_RESERVED;
            else if (r < 79) flaw = FLAW_LONG_DECL;
            else if (r < 85) flaw = FLAW_SHORT_DECL;
            else if (r < 91) flaw = FLAW_BAD_SUM;
            else if (r < 96) flaw = FLAW_CUT;
            else             flaw = FLAW_NOISE;
            if (flaw == FLAW_CUT)
                pay_n = $urandom_range(27, 1);
            else if ($urandom_range(9) == 0)
                pay_n = $urandom_range(64);
            else
                pay_n = $urandom_range(24);
            build_frame(flaw, pay_n, -1);
            send_frame();
            sent += frame_bytes.size();
        end
    endtask

    initial
    begin
        sb = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        data_byte <= 8'd0;
        last      <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_MAX_BYTES;
        cfg_data  <= 32'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset settings
        set_registers(32'hFFFF_FFFF, 16'd1);
        send_case(FLAW_CLEAN, 0, -1);
        send_case(FLAW_CLEAN, 6, 8'h00);
        send_case(FLAW_CLEAN, 6, 8'hFF);
        send_case(FLAW_CUT, 1, -1);
        send_case(FLAW_CUT, 27, -1);
        send_case(FLAW_MAGIC, 3, -1);
        send_case(FLAW_VERSION, 3, -1);
        send_case(FLAW_RESERVED, 3, -1);
        send_case(FLAW_LONG_DECL, 4, -1);
        send_case(FLAW_SHORT_DECL, 4, -1);
        send_case(FLAW_BAD_SUM, 4, -1);
        send_case(FLAW_NOISE, 0, -1);

        // Tightest legal limit: a bare header passes, one more byte does not
        set_registers(32'd28, 16'd0);
        send_case(FLAW_CLEAN, 0, -1);
        send_case(FLAW_CLEAN, 1, -1);

        // Limit below the header size rejects everything
        set_registers(32'd0, 16'hFFFF);
        send_case(FLAW_CLEAN, 0, -1);
        send_case(FLAW_CUT, 5, -1);

        // Random frames; the first phase opens with a long hold on the result side
        set_registers(32'hFFFF_FFFF, 16'($urandom_range(65535)));
        pressure_req = 1'b1;
        run_random(370);

        set_registers(32'($urandom_range(90, 28)), 16'($urandom_range(65535)));
        run_random(370);

        set_registers(32'($urandom_range(60, 28)), 16'hFFFF);
        steady_run = 1'b1;
        run_random(370);
        settle();
        steady_run = 1'b0;

        set_registers(32'hFFFF_FFFF, 16'h0000);
        run_random(370);
        settle();

        $display("Checked %0d frames from %0d bytes across %0d register settings",
                 sb.frames_checked, bytes_taken, settings_run);
        $write("Verdicts: ok %0d, limit %0d, truncated %0d, magic %0d, ",
               sb.status_tally[STATUS_OK], sb.status_tally[STATUS_LIMIT],
               sb.status_tally[STATUS_TRUNCATED], sb.status_tally[STATUS_MAGIC]);
        $display("version %0d, reserved %0d, trailing %0d, checksum %0d",
                 sb.status_tally[STATUS_VERSION], sb.status_tally[STATUS_INVALID],
                 sb.status_tally[STATUS_TRAILING], sb.status_tally[STATUS_CHECKSUM]);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/cfev_pkg.sv
hw/rtl/cfev_hash_step.sv
hw/rtl/cfev_status_eval.sv
hw/rtl/checked_frame_envelope_verifier_core.sv
test/frame_check_scoreboard_pkg.sv
test/checked_frame_envelope_verifier_core_test.sv
